[rtl/fsprng_pkg.sv]
package fsprng_pkg;

    // Fixed sizes of the generator.
    localparam int SEED_BYTES   = 64;
    localparam int DIGEST_BYTES = 20;
    localparam int SEED_WORDS   = SEED_BYTES / 8;
    localparam int WORD_AW      = $clog2(SEED_WORDS);
    localparam int PTR_W        = 5;
    localparam int Q_W          = 160;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int ROUNDS       = 80;

    // Commands of the input channel.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_ENTROPY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_Q_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_HIGH = 2'd2;

    // SHA-1 initial hash value.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_ADD,
        S_LOAD,
        S_ROUNDS,
        S_REDUCE,
        S_KEY_ADD,
        S_RESULT
    } state_t;

    // Requests from the controller to the state memories.
    typedef struct packed {
        logic [WORD_AW-1:0] raddr;
        logic [WORD_AW-1:0] waddr;
        logic [63:0]        wdata;
        logic               key_we;
        logic               seed_we;
        logic               ent_we;
        logic               ent_clear;
    } mem_req_t;

    // Controls of the hash core.
    typedef struct packed {
        logic        load;
        logic [63:0] load_word;
        logic        start;
    } sha_ctrl_t;

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        bswap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

[rtl/fsprng_if.sv]
interface fsprng_in_if;
    import fsprng_pkg::*;
    logic       valid;
    logic       ready;
    logic       command;
    logic [63:0] entropy_word;
    logic [2:0] word_index;
    logic       last_word;

    modport source (output valid, command, entropy_word, word_index, last_word, input ready);
    modport sink (input valid, command, entropy_word, word_index, last_word, output ready);
endinterface

interface fsprng_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] random_byte;

    modport source (output valid, random_byte, input ready);
    modport sink (input valid, random_byte, output ready);
endinterface

[rtl/fsprng_mem.sv]
module fsprng_mem
    import fsprng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic [63:0] key_rd,
    output logic [63:0] seed_rd,
    output logic [63:0] ent_rd
);

    logic [63:0] key_mem  [SEED_WORDS];
    logic [63:0] seed_mem [SEED_WORDS];
    logic [63:0] ent_mem  [SEED_WORDS];

    logic [SEED_WORDS-1:0] key_vld_reg;
    logic [SEED_WORDS-1:0] seed_vld_reg;
    logic [SEED_WORDS-1:0] ent_vld_reg;
    logic [SEED_WORDS-1:0] key_vld_next;
    logic [SEED_WORDS-1:0] seed_vld_next;
    logic [SEED_WORDS-1:0] ent_vld_next;

    logic [63:0] key_q_reg;
    logic [63:0] seed_q_reg;
    logic [63:0] ent_q_reg;
    logic        key_hit_reg;
    logic        seed_hit_reg;
    logic        ent_hit_reg;

    // Memory arrays: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_mem[req.waddr] <= req.wdata;
        end
        if (req.seed_we)
        begin
            seed_mem[req.waddr] <= req.wdata;
        end
        if (req.ent_we)
        begin
            ent_mem[req.waddr] <= req.wdata;
        end
        key_q_reg  <= key_mem[req.raddr];
        seed_q_reg <= seed_mem[req.raddr];
        ent_q_reg  <= ent_mem[req.raddr];
    end

    // Valid bits; an entry that was never written reads as zero.
    always_comb
    begin
        key_vld_next  = key_vld_reg;
        seed_vld_next = seed_vld_reg;
        ent_vld_next  = ent_vld_reg;
        if (req.key_we)
        begin
            key_vld_next[req.waddr] = 1'b1;
        end
        if (req.seed_we)
        begin
            seed_vld_next[req.waddr] = 1'b1;
        end
        if (req.ent_clear)
        begin
            ent_vld_next = '0;
        end
        else if (req.ent_we)
        begin
            ent_vld_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg  <= '0;
            seed_vld_reg <= '0;
            ent_vld_reg  <= '0;
            key_hit_reg  <= 1'b0;
            seed_hit_reg <= 1'b0;
            ent_hit_reg  <= 1'b0;
        end
        else
        begin
            key_vld_reg  <= key_vld_next;
            seed_vld_reg <= seed_vld_next;
            ent_vld_reg  <= ent_vld_next;
            key_hit_reg  <= key_vld_reg[req.raddr];
            seed_hit_reg <= seed_vld_reg[req.raddr];
            ent_hit_reg  <= ent_vld_reg[req.raddr];
        end
    end

    assign key_rd  = key_hit_reg  ? key_q_reg  : '0;
    assign seed_rd = seed_hit_reg ? seed_q_reg : '0;
    assign ent_rd  = ent_hit_reg  ? ent_q_reg  : '0;

endmodule

[rtl/fsprng_sha1.sv]
module fsprng_sha1
    import fsprng_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sha_ctrl_t    ctrl,
    output logic         done,
    output logic [159:0] digest
);

    logic [31:0] sr_reg [16];
    logic [31:0] sr_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    logic [6:0]  rnd_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;
    logic [31:0] w_new;

    // Round function and constant for the current round.
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + sr_reg[0];
        w_new = sr_reg[13] ^ sr_reg[8] ^ sr_reg[2] ^ sr_reg[0];
    end

    // Message schedule as a 16-word shift line; tap 0 is the word of this round.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sr_next[i] = sr_reg[i];
        end
        if (ctrl.load)
        begin
            for (int i = 0; i < 14; i++)
            begin
                sr_next[i] = sr_reg[i + 2];
            end
            sr_next[14] = bswap32(ctrl.load_word[31:0]);
            sr_next[15] = bswap32(ctrl.load_word[63:32]);
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sr_next[i] = sr_reg[i + 1];
            end
            sr_next[15] = {w_new[30:0], w_new[31]};
        end
    end

    // Working variables.
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (ctrl.start)
        begin
            a_next = IV0;
            b_next = IV1;
            c_next = IV2;
            d_next = IV3;
            e_next = IV4;
        end
        else if (busy_reg)
        begin
            a_next = t;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            sr_reg[i] <= sr_next[i];
        end
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        if (fin_reg)
        begin
            h0_reg <= IV0 + a_reg;
            h1_reg <= IV1 + b_reg;
            h2_reg <= IV2 + c_reg;
            h3_reg <= IV3 + d_reg;
            h4_reg <= IV4 + e_reg;
        end
    end

    // Round counter and completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
            if (ctrl.start)
            begin
                rnd_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'(ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign digest = {h0_reg, h1_reg, h2_reg, h3_reg, h4_reg};

endmodule

[rtl/fsprng_modq.sv]
module fsprng_modq
    import fsprng_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [Q_W-1:0] value,
    input  logic [Q_W-1:0] modulus,
    output logic           done,
    output logic [Q_W-1:0] result
);

    logic [Q_W-1:0] v_reg;
    logic [Q_W-1:0] r_reg;
    logic [7:0]     bit_cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [Q_W:0]   r2;
    logic [Q_W:0]   diff;

    // One restoring division step: shift in the next bit, subtract if it fits.
    always_comb
    begin
        r2   = {r_reg, v_reg[Q_W-1]};
        diff = r2 - {1'b0, modulus};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            r_reg <= (modulus == '0) ? value : '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[Q_W-2:0], 1'b0};
            r_reg <= diff[Q_W] ? r2[Q_W-1:0] : diff[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                bit_cnt_reg <= '0;
                busy_reg    <= (modulus != '0);
                done_reg    <= (modulus == '0);
            end
            else if (busy_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg + 8'd1;
                if (bit_cnt_reg == 8'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[rtl/fips186_sha1_prng_unit.sv]
// SHA-1 based FIPS 186-2 style byte generator with a 512-bit key. Every input beat gives
// exactly one output beat. A byte request served from the stored 20-byte digest and an
// entropy word that is not the last one are answered straight from the idle state. The
// last entropy word adds the 512-bit entropy buffer to the key one 64-bit word per cycle,
// writes the sum into the seed and clears the entropy buffer. A request that finds the
// digest used up runs a refill: the seed is read into the hash core, the 80 SHA-1 rounds
// run at one round per cycle, the digest is reduced modulo q bit-serially (it passes
// through unreduced when q is zero), then the 512-bit key update runs; so one byte in
// twenty waits for a refill. Key, seed and entropy live in 8 x 64-bit memories whose
// entries have valid bits cleared by reset, so no clearing pass is needed.
module fips186_sha1_prng_unit
    import fsprng_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fsprng_in_if.sink             in_ch,
    fsprng_out_if.source          out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [3:0]       cnt_reg, cnt_next;
    logic             carry_reg, carry_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [7:0]       pend_reg, pend_next;
    logic [63:0]      q_low_reg, q_mid_reg;
    logic [31:0]      q_high_reg;

    mem_req_t    mem_req;
    sha_ctrl_t   sha_ctrl;
    logic [63:0] key_rd, seed_rd, ent_rd;
    logic        sha_done;
    logic [159:0] digest;
    logic        red_start;
    logic        red_done;
    logic [Q_W-1:0] red_value;
    logic [Q_W-1:0] red_result;

    logic        accept;
    logic        slot_free;
    logic        need_refill;
    logic [63:0] add_word;
    logic [64:0] sum;
    logic [7:0]  ptr_byte;

    fsprng_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .key_rd  (key_rd),
        .seed_rd (seed_rd),
        .ent_rd  (ent_rd)
    );

    fsprng_sha1 u_sha1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sha_ctrl),
        .done   (sha_done),
        .digest (digest)
    );

    fsprng_modq u_modq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .value   (red_value),
        .modulus ({q_high_reg, q_mid_reg, q_low_reg}),
        .done    (red_done),
        .result  (red_result)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_low_reg  <= '0;
            q_mid_reg  <= '0;
            q_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_Q_LOW:  q_low_reg  <= cfg_data;
                REG_Q_MID:  q_mid_reg  <= cfg_data;
                REG_Q_HIGH: q_high_reg <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // Handshake terms and shared datapath values.
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign need_refill = (ptr_reg >= PTR_W'(DIGEST_BYTES));
    assign ptr_byte    = digest[159 - 8 * int'(ptr_reg) -: 8];
    assign red_value   = {bswap32(digest[31:0]), bswap32(digest[63:32]),
                          bswap32(digest[95:64]), bswap32(digest[127:96]),
                          bswap32(digest[159:128])};

    always_comb
    begin
        case (cnt_reg[2:0])
            3'd1:    add_word = red_result[63:0];
            3'd2:    add_word = red_result[127:64];
            3'd3:    add_word = {32'd0, red_result[159:128]};
            default: add_word = '0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.command == CMD_ENTROPY)
                    begin
                        if (in_ch.last_word)
                        begin
                            state_next = S_SEED_ADD;
                        end
                    end
                    else if (need_refill)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_SEED_ADD:
            begin
                if (cnt_reg == 4'(SEED_WORDS))
                begin
                    state_next = S_RESULT;
                end
            end
            S_LOAD:
            begin
                if (cnt_reg == 4'(SEED_WORDS))
                begin
                    state_next = S_ROUNDS;
                end
            end
            S_ROUNDS:
            begin
                if (sha_done)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (red_done)
                begin
                    state_next = S_KEY_ADD;
                end
            end
            S_KEY_ADD:
            begin
                if (cnt_reg == 4'(SEED_WORDS))
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        in_ch.ready        = (state_reg == S_IDLE) && slot_free;
        cnt_next           = '0;
        carry_next         = carry_reg;
        ptr_next           = ptr_reg;
        pend_next          = pend_reg;
        out_valid_next     = out_valid_reg && !out_ch.ready;
        out_byte_next      = out_byte_reg;
        mem_req            = '0;
        mem_req.raddr      = cnt_reg[WORD_AW-1:0];
        mem_req.waddr      = WORD_AW'(cnt_reg - 4'd1);
        sha_ctrl           = '0;
        sha_ctrl.load_word = seed_rd;
        red_start          = 1'b0;
        sum                = '0;
        case (state_reg)
            S_IDLE:
            begin
                mem_req.waddr = in_ch.word_index;
                mem_req.wdata = in_ch.entropy_word;
                carry_next    = 1'b0;
                if (accept)
                begin
                    if (in_ch.command == CMD_ENTROPY)
                    begin
                        mem_req.ent_we = 1'b1;
                        pend_next      = '0;
                        if (!in_ch.last_word)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = '0;
                        end
                    end
                    else if (!need_refill)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = ptr_byte;
                        ptr_next       = ptr_reg + PTR_W'(1);
                    end
                end
            end
            S_SEED_ADD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg != '0)
                begin
                    sum             = {1'b0, ent_rd} + {1'b0, key_rd} + 65'(carry_reg);
                    mem_req.wdata   = sum[63:0];
                    mem_req.seed_we = 1'b1;
                    carry_next      = sum[64];
                end
                if (cnt_reg == 4'(SEED_WORDS))
                begin
                    mem_req.ent_clear = 1'b1;
                    cnt_next          = '0;
                end
            end
            S_LOAD:
            begin
                cnt_next      = cnt_reg + 4'd1;
                sha_ctrl.load = (cnt_reg != '0);
                if (cnt_reg == 4'(SEED_WORDS))
                begin
                    sha_ctrl.start = 1'b1;
                    cnt_next       = '0;
                end
            end
            S_ROUNDS:
            begin
                red_start  = sha_done;
                carry_next = 1'b1;
            end
            S_REDUCE:
            begin
                carry_next = 1'b1;
            end
            S_KEY_ADD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg != '0)
                begin
                    sum             = {1'b0, key_rd} + {1'b0, add_word} + 65'(carry_reg);
                    mem_req.wdata   = sum[63:0];
                    mem_req.key_we  = 1'b1;
                    mem_req.seed_we = 1'b1;
                    carry_next      = sum[64];
                end
                if (cnt_reg == 4'(SEED_WORDS))
                begin
                    cnt_next  = '0;
                    pend_next = digest[159:152];
                    ptr_next  = PTR_W'(1);
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_reg;
                end
            end
            default: ;
        endcase
        out_ch.valid       = out_valid_reg;
        out_ch.random_byte = out_byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            carry_reg     <= 1'b0;
            ptr_reg       <= PTR_W'(DIGEST_BYTES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            carry_reg     <= carry_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        pend_reg     <= pend_next;
    end

    // Checks.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(DIGEST_BYTES))
        else $error("byte pointer beyond digest");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input accepted while busy");

    a_refill_ends_at_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KEY_ADD && cnt_reg == 4'(SEED_WORDS)) |=> (ptr_reg == PTR_W'(1)))
        else $error("refill did not restart the byte pointer");

endmodule
